// ===== rtl/core/wat_pkg.sv =====
// Shared constants, types and codes for the waypoint arrival tracker.
`default_nettype none

package wat_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int COORD_BITS    = 20;

  localparam int AW     = $clog2(MAX_WAYPOINTS);      // route table address
  localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);  // count / index, holds MAX
  localparam int MAG_W  = COORD_BITS + 1;             // |a - b|
  localparam int SQ_W   = 2 * MAG_W;                  // one squared term
  localparam int SUM_W  = SQ_W + 2;                   // sum of three squares, even
  localparam int ROOT_W = SUM_W / 2;
  localparam int LEN_W  = 32;
  localparam int RAD_W  = 16;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int CMP_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(100);  // 10.0 m in dm

  // item kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;

  // config port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_RADIUS = 1'b0;

  // stream widths
  localparam int IN_BITS     = 3 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 + 2 * CNT_W + 3 * COORD_BITS + LEN_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // x in the lowest bits, matching the input packing
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

endpackage

`default_nettype wire

// ===== rtl/core/wat_sqr.sv =====
// Bit-serial squarer of the difference of two coordinates.
`default_nettype none

module wat_sqr (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start_i,
  input  wire  wat_pkg::coord_t a_i,
  input  wire  wat_pkg::coord_t b_i,
  output logic                  done_o,
  output logic [wat_pkg::SQ_W-1:0] sq_o
);
  import wat_pkg::*;

  localparam int CW = $clog2(MAG_W + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [SQ_W-1:0]  mcand_r, mcand_nxt;
  logic [MAG_W-1:0] mplier_r, mplier_nxt;
  logic [SQ_W-1:0]  acc_r, acc_nxt;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0] mag;

  assign diff = MAG_W'(signed'(a_i)) - MAG_W'(signed'(b_i));
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  always_comb begin
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    done_nxt   = (cnt_r == CW'(1));
    if (start_i) begin
      cnt_nxt    = CW'(MAG_W);
      mcand_nxt  = SQ_W'(mag);
      mplier_nxt = mag;
      acc_nxt    = '0;
    end else if (cnt_r != '0) begin
      // one multiplier bit per cycle
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[SQ_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[MAG_W-1:1]};
      cnt_nxt    = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign done_o = done_r;
  assign sq_o   = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> cnt_r == '0)
    else $error("squarer restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/core/wat_isqrt.sv =====
// Digit-serial floor square root, two radicand bits per cycle.
`default_nettype none

module wat_isqrt (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start_i,
  input  wire  [wat_pkg::SUM_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [wat_pkg::ROOT_W-1:0]  root_o
);
  import wat_pkg::*;

  localparam int CW    = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_comb begin
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    done_nxt = (cnt_r == CW'(1));
    if (start_i) begin
      cnt_nxt  = CW'(ROOT_W);
      rad_nxt  = rad_i;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cnt_r != '0) begin
      rad_nxt  = {rad_r[SUM_W-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done_o = done_r;
  assign root_o = root_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> cnt_r == '0)
    else $error("root unit restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/core/waypoint_arrival_tracker.sv =====
// Waypoint sequencer with arrival radius: control, route table, config port.
// Steps from input accept to result valid: an item that reads no reference point goes straight
//   to the target read, skipped when the table ends empty; a check of a pending target runs three
//   parallel bit-serial squarers; an append with a segment runs them, then the 2-bit root unit.
// Throughput: one item at a time, the next taken only after the previous result is loaded; an item
//   may be taken while the previous result still waits in the output register. Reset (rst_n,
//   synchronous): empty route, target 0, length 0, radius 100 dm.
`default_nettype none

module waypoint_arrival_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  // input stream
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [wat_pkg::IN_TDATA_W-1:0]   in_tdata,   // x_coord, y_coord, z_coord, pad
  input  wire  [1:0]                       in_tuser,   // kind
  // result stream
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // reached, table_full, route_done, target_index, waypoint_count,
  // target_x, target_y, target_z, route_length, pad
  output logic [wat_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [wat_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire  [wat_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [wat_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import wat_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;  // waiting for an item
  localparam logic [3:0] S_ISSUE  = 4'd1;  // table write / read of the reference point
  localparam logic [3:0] S_MWAIT  = 4'd2;  // read data valid, squarers start
  localparam logic [3:0] S_SQ     = 4'd3;  // squarers running
  localparam logic [3:0] S_DECIDE = 4'd4;  // radius compare, or root start
  localparam logic [3:0] S_ROOT   = 4'd5;  // root running
  localparam logic [3:0] S_TRD    = 4'd6;  // read the reported target
  localparam logic [3:0] S_TWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;  // load the output register

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  point_t           pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic [RSQ_W-1:0] rsq_r;
  logic             reached_r, reached_nxt;
  logic             full_r, full_nxt;
  logic [SUM_W-1:0] dsq_r, dsq_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // route table
  point_t           mem [MAX_WAYPOINTS];
  point_t           mem_rd_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_raddr;

  // serial units
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [2:0]        sq_done;
  logic              sq_start;
  logic              rt_start, rt_done;
  logic [ROOT_W-1:0] root;
  logic [LEN_W:0]    len_sum;

  logic accept_in, cfg_wr, cfg_hit, out_free;
  logic [AW-1:0] last_addr, tgt_addr;

  assign accept_in = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_RADIUS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(CFG_DW-RAD_W){1'b0}}, radius_r} : '0;

  assign last_addr = AW'(count_r - CNT_W'(1));
  // reported target: current one, or the last waypoint when past the end
  assign tgt_addr  = (target_r < count_r) ? target_r[AW-1:0] : last_addr;

  assign sq_start = (state_r == S_MWAIT);
  assign rt_start = (state_r == S_DECIDE) && (kind_r == KIND_APPEND);
  assign len_sum  = {1'b0, length_r} + (LEN_W+1)'(root);

  wat_sqr u_sqr_x (
    .clk(clk), .rst_n(rst_n), .start_i(sq_start),
    .a_i(pos_r.x), .b_i(mem_rd_r.x), .done_o(sq_done[0]), .sq_o(sq_x)
  );
  wat_sqr u_sqr_y (
    .clk(clk), .rst_n(rst_n), .start_i(sq_start),
    .a_i(pos_r.y), .b_i(mem_rd_r.y), .done_o(sq_done[1]), .sq_o(sq_y)
  );
  wat_sqr u_sqr_z (
    .clk(clk), .rst_n(rst_n), .start_i(sq_start),
    .a_i(pos_r.z), .b_i(mem_rd_r.z), .done_o(sq_done[2]), .sq_o(sq_z)
  );

  wat_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start_i(rt_start),
    .rad_i(dsq_r), .done_o(rt_done), .root_o(root)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    length_nxt    = length_r;
    radius_nxt    = cfg_wr ? cfg_pwdata[RAD_W-1:0] : radius_r;
    reached_nxt   = reached_r;
    full_nxt      = full_r;
    dsq_nxt       = dsq_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = tgt_addr;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          kind_nxt    = in_tuser;
          pos_nxt     = point_t'(in_tdata[IN_BITS-1:0]);
          reached_nxt = 1'b0;
          full_nxt    = 1'b0;
          state_nxt   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_TRD;
        case (kind_r)
          KIND_APPEND: begin
            if (count_r >= CNT_W'(MAX_WAYPOINTS)) begin
              full_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (count_r != '0) begin
                // previous waypoint for the segment length
                mem_re    = 1'b1;
                mem_raddr = last_addr;
                state_nxt = S_MWAIT;
              end
            end
          end
          KIND_CLEAR: begin
            count_nxt  = '0;
            length_nxt = '0;
          end
          KIND_CHECK: begin
            if (target_r < count_r) begin
              mem_re    = 1'b1;
              mem_raddr = target_r[AW-1:0];
              state_nxt = S_MWAIT;
            end
          end
          default: ;
        endcase
      end
      S_MWAIT: state_nxt = S_SQ;
      S_SQ: begin
        if (&sq_done) begin
          dsq_nxt   = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (kind_r == KIND_APPEND) begin
          state_nxt = S_ROOT;
        end else begin
          if (CMP_W'(dsq_r) <= CMP_W'(rsq_r)) begin
            target_nxt  = target_r + CNT_W'(1);
            reached_nxt = 1'b1;
          end
          state_nxt = S_TRD;
        end
      end
      S_ROOT: begin
        if (rt_done) begin
          length_nxt = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
          state_nxt  = S_TRD;
        end
      end
      S_TRD: begin
        if (count_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = tgt_addr;
          state_nxt = S_TWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_TWAIT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_data_nxt = '0;
          out_data_nxt[OUT_BITS-1:0] = {
            length_r,
            (count_r != '0) ? mem_rd_r.z : coord_t'(0),
            (count_r != '0) ? mem_rd_r.y : coord_t'(0),
            (count_r != '0) ? mem_rd_r.x : coord_t'(0),
            count_r,
            target_r,
            (target_r >= count_r),
            full_r,
            reached_r
          };
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      target_r    <= '0;
      length_r    <= '0;
      radius_r    <= RADIUS_RESET;
      reached_r   <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      target_r    <= target_nxt;
      length_r    <= length_nxt;
      radius_r    <= radius_nxt;
      reached_r   <= reached_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    dsq_r      <= dsq_nxt;
    out_data_r <= out_data_nxt;
    rsq_r      <= RSQ_W'(radius_r) * RSQ_W'(radius_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[AW-1:0]] <= pos_r;
    if (mem_re) mem_rd_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r < $past(count_r)) |->
      ($past(state_r) == S_ISSUE) && ($past(kind_r) == KIND_CLEAR))
    else $error("waypoint count fell without a clear");

  a_target_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (target_r != $past(target_r)) |->
      (target_r == $past(target_r) + CNT_W'(1)) && ($past(state_r) == S_DECIDE))
    else $error("target index moved other than by one arrival");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

endmodule

`default_nettype wire
